// ----- rtl/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// cct_pkg
// Types, constants and calendar helpers for the calendar clock tick unit.
// ----------------------------------------------------------------------------
package cct_pkg;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  localparam logic [5:0]  SEC_MAX     = 6'd59;
  localparam logic [5:0]  MIN_MAX     = 6'd59;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [2:0]  WDAY_MAX    = 3'd6;
  localparam logic [3:0]  MONTH_MAX   = 4'd11;
  localparam logic [3:0]  MONTH_FEB   = 4'd1;
  localparam logic [3:0]  MONTH_MAR   = 4'd2;
  localparam logic [3:0]  SET_MON_MAX = 4'd12;

  // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound.
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [2:0]  set_weekday;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [2:0]  now_weekday;
    logic [8:0]  now_yearday;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
  } out_item_t;

  // Gregorian leap test. With the year a multiple of 4, a multiple of 100 is
  // a multiple of 25, and a multiple of 400 is also a multiple of 16.
  function automatic logic is_leap(input logic [15:0] y);
    logic [31:0] prod;
    logic        div25;
    prod  = 32'(y) * 32'(INV25);
    div25 = (prod[15:0] <= DIV25_LIMIT);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Length of a 0-based month; codes past December take December.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1:                   d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

  // Days in the year before the first of a 0-based month, non-leap year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/calendar_clock_tick_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_tick_unit
// Gregorian calendar counter: tick one second, load date and time, or read.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries one command per
//   transfer: advance one second, load a new date and time, or read only.
//   Every accepted transfer yields exactly one result on the output channel
//   (out_valid / out_stall / out_data): the calendar as it stands after the
//   command, with month, weekday and day of year counted from 1.
//   The result is registered: a transfer accepted in one cycle is shown in
//   the next. Throughput is one item per cycle when out_stall is low; the
//   whole second-to-year carry chain and the day-of-year lookup for a load
//   fit in one pass between the calendar registers and the result register.
//   While the receiver stalls a pending result, in_stall is raised and the
//   calendar holds; the next transfer is taken in the same cycle the pending
//   result leaves.
//   Reset (rst_n low, synchronous) sets 00:00:00 on day 1 of January, year
//   0, first weekday, and empties the result register.
//   Loaded fields out of range are saturated; a day past the month end is
//   kept and wraps at the next day carry. The year wraps at 65535.
// ----------------------------------------------------------------------------
module calendar_clock_tick_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cct_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cct_pkg::out_item_t out_data
);

  // Calendar state, 0-based where the counters start from zero.
  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [2:0]  wday_r,  wday_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r,  year_nxt;
  logic [8:0]  yday_r,  yday_nxt;

  logic               out_valid_r;
  cct_pkg::out_item_t out_data_r, out_data_nxt;

  logic accept;

  // Tick path signals.
  logic       cur_leap;
  logic [4:0] cur_mdays;
  logic [5:0] day_inc;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;

  // Load path signals.
  logic       set_leap;
  logic [3:0] ld_month;
  logic [4:0] ld_day;
  logic [2:0] ld_wday;
  logic [4:0] ld_hour;
  logic [5:0] ld_min;
  logic [5:0] ld_sec;
  logic [8:0] ld_yday;

  // Take a new transfer unless a finished result is still held back.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // ---- one-second advance -------------------------------------------------
  assign cur_leap   = cct_pkg::is_leap(year_r);
  assign cur_mdays  = cct_pkg::month_days(month_r, cur_leap);
  // Six bits here: a loaded day 31 must compare past the month end, not wrap.
  assign day_inc    = {1'b0, day_r} + 6'd1;
  assign sec_wrap   = (sec_r >= cct_pkg::SEC_MAX);
  assign min_wrap   = sec_wrap && (min_r >= cct_pkg::MIN_MAX);
  assign hour_wrap  = min_wrap && (hour_r >= cct_pkg::HOUR_MAX);
  assign day_wrap   = hour_wrap && (day_inc > {1'b0, cur_mdays});
  assign month_wrap = day_wrap && (month_r >= cct_pkg::MONTH_MAX);

  // ---- load: saturate each field into range -------------------------------
  assign set_leap = cct_pkg::is_leap(in_data.set_year);

  always_comb begin
    logic [3:0] m1;
    m1 = in_data.set_month;
    if (m1 == 4'd0) begin
      m1 = 4'd1;
    end else if (m1 > cct_pkg::SET_MON_MAX) begin
      m1 = cct_pkg::SET_MON_MAX;
    end
    ld_month = m1 - 4'd1;
    ld_day   = (in_data.set_day == 5'd0) ? 5'd1 : in_data.set_day;
    ld_wday  = (in_data.set_weekday == 3'd0) ? 3'd0 : in_data.set_weekday - 3'd1;
    ld_hour  = (in_data.set_hour > cct_pkg::HOUR_MAX) ? cct_pkg::HOUR_MAX
                                                      : in_data.set_hour;
    ld_min   = (in_data.set_minute > cct_pkg::MIN_MAX) ? cct_pkg::MIN_MAX
                                                       : in_data.set_minute;
    ld_sec   = (in_data.set_second > cct_pkg::SEC_MAX) ? cct_pkg::SEC_MAX
                                                       : in_data.set_second;
    // Day of year: days before the month, leap day from March on, then day.
    ld_yday  = cct_pkg::days_before(ld_month)
             + {8'd0, (set_leap && (ld_month >= cct_pkg::MONTH_MAR))}
             + {4'd0, ld_day} - 9'd1;
  end

  // ---- next calendar state ------------------------------------------------
  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    wday_nxt  = wday_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    yday_nxt  = yday_r;
    unique case (in_data.cmd)
      cct_pkg::CMD_TICK: begin
        sec_nxt = sec_wrap ? 6'd0 : sec_r + 6'd1;
        if (sec_wrap) begin
          min_nxt = min_wrap ? 6'd0 : min_r + 6'd1;
        end
        if (min_wrap) begin
          hour_nxt = hour_wrap ? 5'd0 : hour_r + 5'd1;
        end
        if (hour_wrap) begin
          wday_nxt = (wday_r >= cct_pkg::WDAY_MAX) ? 3'd0 : wday_r + 3'd1;
          day_nxt  = day_wrap ? 5'd1 : day_inc[4:0];
          yday_nxt = yday_r + 9'd1;
        end
        if (day_wrap) begin
          month_nxt = month_wrap ? 4'd0 : month_r + 4'd1;
        end
        // Roll the year over and restart the day of year.
        if (month_wrap) begin
          year_nxt = year_r + 16'd1;
          yday_nxt = 9'd0;
        end
      end
      cct_pkg::CMD_LOAD: begin
        sec_nxt   = ld_sec;
        min_nxt   = ld_min;
        hour_nxt  = ld_hour;
        wday_nxt  = ld_wday;
        day_nxt   = ld_day;
        month_nxt = ld_month;
        year_nxt  = in_data.set_year;
        yday_nxt  = ld_yday;
      end
      default: begin
        // Read only, and the unused code: hold the calendar.
      end
    endcase
  end

  // Result is the new state, with the 0-based counters shown from 1.
  always_comb begin
    out_data_nxt.now_year    = year_nxt;
    out_data_nxt.now_month   = month_nxt + 4'd1;
    out_data_nxt.now_day     = day_nxt;
    out_data_nxt.now_weekday = wday_nxt + 3'd1;
    out_data_nxt.now_yearday = yday_nxt + 9'd1;
    out_data_nxt.now_hour    = hour_nxt;
    out_data_nxt.now_minute  = min_nxt;
    out_data_nxt.now_second  = sec_nxt;
  end

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hour_r      <= 5'd0;
      wday_r      <= 3'd0;
      day_r       <= 5'd1;
      month_r     <= 4'd0;
      year_r      <= 16'd0;
      yday_r      <= 9'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        hour_r      <= hour_nxt;
        wday_r      <= wday_nxt;
        day_r       <= day_nxt;
        month_r     <= month_nxt;
        year_r      <= year_nxt;
        yday_r      <= yday_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        // Drop the result once it has been transferred.
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload register: load on every accepted transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- test/tb_calendar_clock_tick_unit.sv -----
// ----------------------------------------------------------------------------
// tb_calendar_clock_tick_unit
// Self-checking bench for the Gregorian calendar counter: drives tick, load
// and read commands over the valid/stall input channel, predicts every result
// with an independent calendar model and compares each output transfer
// field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_calendar_clock_tick_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused command code; the block treats it as a plain read.
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  // Non-leap month lengths, indexed by the 0-based month.
  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  cct_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cct_pkg::out_item_t out_data;

  // Predicted calendar after every accepted command, oldest first.
  cct_pkg::out_item_t cal_q [$];
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;

  // Traffic shaping knobs, set by the test tasks.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Predicted calendar registers: month, weekday and day of year are 0-based.
  logic [5:0]  cal_sec = '0;
  logic [5:0]  cal_min = '0;
  logic [4:0]  cal_hour = '0;
  logic [2:0]  cal_wday = '0;
  logic [4:0]  cal_mday = 5'd1;
  logic [3:0]  cal_mon = '0;
  logic [15:0] cal_year = '0;
  logic [8:0]  cal_yday = '0;

  calendar_clock_tick_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock: high half, then low half.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar prediction
  // ---------------------------------------------------------------------------

  // Gregorian rule on the full year; year zero divides by 400 and is leap.
  function automatic bit leap_year(input logic [15:0] yr);
    int unsigned y;
    y = 32'(yr);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(input logic [3:0] mon0, input logic [15:0] yr);
    if (mon0 == cct_pkg::MONTH_FEB) begin
      return leap_year(yr) ? 29 : 28;
    end
    return (mon0 > cct_pkg::MONTH_MAX) ? MONTH_LEN[cct_pkg::MONTH_MAX] : MONTH_LEN[mon0];
  endfunction

  // One second forward, rippling carries up to the year.
  function automatic void advance_one_second();
    int next_mday;
    if (cal_sec != cct_pkg::SEC_MAX) begin
      cal_sec = cal_sec + 6'd1;
      return;
    end
    cal_sec = '0;
    if (cal_min != cct_pkg::MIN_MAX) begin
      cal_min = cal_min + 6'd1;
      return;
    end
    cal_min = '0;
    if (cal_hour != cct_pkg::HOUR_MAX) begin
      cal_hour = cal_hour + 5'd1;
      return;
    end
    cal_hour = '0;
    // Day carry: day of year and weekday move on every midnight.
    cal_yday = cal_yday + 9'd1;
    cal_wday = (cal_wday == cct_pkg::WDAY_MAX) ? 3'd0 : cal_wday + 3'd1;
    // Count in int so a day of 31 does not wrap inside five bits.
    next_mday = int'(cal_mday) + 1;
    if (next_mday <= month_length(cal_mon, cal_year)) begin
      cal_mday = 5'(next_mday);
      return;
    end
    cal_mday = 5'd1;
    if (cal_mon != cct_pkg::MONTH_MAX) begin
      cal_mon = cal_mon + 4'd1;
      return;
    end
    cal_mon  = '0;
    cal_yday = '0;
    cal_year = cal_year + 16'd1;
  endfunction

  // Load with every field saturated into its range; day of year is rebuilt
  // from the loaded month and day. A day past the month end is kept.
  function automatic void load_calendar(input cct_pkg::in_item_t c);
    logic [3:0] mon1;
    int         ydays;
    int         i;
    cal_year = c.set_year;
    if (c.set_month == 4'd0) begin
      mon1 = 4'd1;
    end else if (c.set_month > cct_pkg::SET_MON_MAX) begin
      mon1 = cct_pkg::SET_MON_MAX;
    end else begin
      mon1 = c.set_month;
    end
    cal_mday = (c.set_day == 5'd0) ? 5'd1 : c.set_day;
    cal_wday = (c.set_weekday == 3'd0) ? 3'd0 : c.set_weekday - 3'd1;
    cal_hour = (c.set_hour > cct_pkg::HOUR_MAX) ? cct_pkg::HOUR_MAX : c.set_hour;
    cal_min  = (c.set_minute > cct_pkg::MIN_MAX) ? cct_pkg::MIN_MAX : c.set_minute;
    cal_sec  = (c.set_second > cct_pkg::SEC_MAX) ? cct_pkg::SEC_MAX : c.set_second;
    cal_mon  = mon1 - 4'd1;
    ydays = 0;
    for (i = 0; i < int'(cal_mon); i++) begin
      ydays += month_length(4'(i), cal_year);
    end
    cal_yday = 9'(ydays + int'(cal_mday) - 1);
  endfunction

  // Apply one command and return the calendar as the block should show it.
  function automatic cct_pkg::out_item_t apply_command(input cct_pkg::in_item_t c);
    cct_pkg::out_item_t r;
    case (c.cmd)
      cct_pkg::CMD_TICK: advance_one_second();
      cct_pkg::CMD_LOAD: load_calendar(c);
      default: ;  // read and the spare code leave the time alone
    endcase
    r.now_year    = cal_year;
    r.now_month   = cal_mon + 4'd1;
    r.now_day     = cal_mday;
    r.now_weekday = cal_wday + 3'd1;
    r.now_yearday = cal_yday + 9'd1;
    r.now_hour    = cal_hour;
    r.now_minute  = cal_min;
    r.now_second  = cal_sec;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor and result checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Sample both channels at the rising edge. Pop before push: a result leaving
  // at this edge always belongs to a command taken at an earlier edge.
  always @(posedge clk) begin : xfer_mon
    cct_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (cal_q.size() == 0) begin
          $error("result transfer with no command pending");
          err_cnt++;
        end else begin
          want = cal_q.pop_front();
          check_field("now_year", want.now_year, out_data.now_year);
          check_field("now_month", 16'(want.now_month), 16'(out_data.now_month));
          check_field("now_day", 16'(want.now_day), 16'(out_data.now_day));
          check_field("now_weekday", 16'(want.now_weekday),
                      16'(out_data.now_weekday));
          check_field("now_yearday", 16'(want.now_yearday),
                      16'(out_data.now_yearday));
          check_field("now_hour", 16'(want.now_hour), 16'(out_data.now_hour));
          check_field("now_minute", 16'(want.now_minute), 16'(out_data.now_minute));
          check_field("now_second", 16'(want.now_second), 16'(out_data.now_second));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        cal_q.push_back(apply_command(in_data));
      end
    end
  end

  // Watchdog: end the run as failed once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fully random item, every bit of every field free.
  function automatic cct_pkg::in_item_t random_payload();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(cct_pkg::in_item_t)-1:0];
  endfunction

  function automatic cct_pkg::in_item_t make_load(input logic [15:0] yr,
                                                  input logic [3:0] mon,
                                                  input logic [4:0] day,
                                                  input logic [2:0] wd,
                                                  input logic [4:0] hh,
                                                  input logic [5:0] mm,
                                                  input logic [5:0] ss);
    cct_pkg::in_item_t it;
    it.cmd         = cct_pkg::CMD_LOAD;
    it.set_year    = yr;
    it.set_month   = mon;
    it.set_day     = day;
    it.set_weekday = wd;
    it.set_hour    = hh;
    it.set_minute  = mm;
    it.set_second  = ss;
    return it;
  endfunction

  // Non-load command; the set fields ride along as random junk.
  function automatic cct_pkg::in_item_t make_cmd(input logic [1:0] code);
    cct_pkg::in_item_t it;
    it     = random_payload();
    it.cmd = code;
    return it;
  endfunction

  // Bias toward years that exercise the leap rule and the year wrap.
  function automatic logic [15:0] pick_year();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(65535));
      1:       return 16'(400 * $urandom_range(163));
      2:       return 16'(100 * $urandom_range(655));
      3:       return 16'(4 * $urandom_range(16383));
      default: return 16'hFFFF;
    endcase
  endfunction

  // Offer one command, with random idle cycles first, and hold it until the
  // transfer happens. Valid stays high on return so back-to-back items never
  // drop it; the next call lowers it only if it idles.
  task automatic push_command(input cct_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted result has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (cal_q.size() != 0);
  endtask

  // Load a moment just before midnight near a month end, then tick through it
  // with an occasional read mixed in.
  task automatic send_rollover_burst(output int count);
    cct_pkg::in_item_t it;
    int                ticks;
    int                k;
    it = make_load(pick_year(), 4'($urandom_range(1, 12)), 5'($urandom_range(26, 31)),
                   3'($urandom_range(1, 7)), cct_pkg::HOUR_MAX, cct_pkg::MIN_MAX,
                   6'($urandom_range(45, 59)));
    if ($urandom_range(3) == 0) begin
      // Sometimes start on any day of the month, at minute 58 or 59, for variety.
      it.set_day    = 5'($urandom_range(1, 31));
      it.set_minute = 6'($urandom_range(58, 59));
    end
    push_command(it);
    ticks = $urandom_range(4, 24);
    for (k = 0; k < ticks; k++) begin
      case ($urandom_range(9))
        0:       it = make_cmd(cct_pkg::CMD_READ);
        1:       it = make_cmd(CMD_SPARE);
        default: it = make_cmd(cct_pkg::CMD_TICK);
      endcase
      push_command(it);
    end
    count = ticks + 1;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset state, saturation at both ends, every wrap and the leap corners.
  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    push_command(make_cmd(cct_pkg::CMD_READ));     // reset calendar
    push_command(make_cmd(cct_pkg::CMD_TICK));
    push_command(make_cmd(CMD_SPARE));             // spare code reads only
    // All-ones load saturates to Dec 31 23:59:59, weekday 7.
    push_command(make_load(16'hFFFF, 4'hF, 5'h1F, 3'h7, 5'h1F, 6'h3F, 6'h3F));
    // Wrap everything: year 65535 -> 0, weekday 7 -> 1, day of year -> 1.
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // All-zero load saturates month, day and weekday up to 1.
    push_command(make_load(16'd0, 4'd0, 5'd0, 3'd0, 5'd0, 6'd0, 6'd0));
    // Year zero is leap.
    push_command(make_load(16'd0, 4'd2, 5'd28, 3'd3, 5'd23, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // Century, not leap.
    push_command(make_load(16'd1900, 4'd2, 5'd28, 3'd4, 5'd23, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // Multiple of 400, leap.
    push_command(make_load(16'd2000, 4'd2, 5'd28, 3'd1, 5'd23, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // February 31 is kept and wraps to March 1 at midnight.
    push_command(make_load(16'd2023, 4'd2, 5'd31, 3'd2, 5'd23, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_READ));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // Last day of a leap year: day of year 366.
    push_command(make_load(16'd2024, 4'd12, 5'd31, 3'd5, 5'd12, 6'd34, 6'd56));
    push_command(make_cmd(cct_pkg::CMD_READ));
    // Thirty-day month end.
    push_command(make_load(16'd2024, 4'd4, 5'd30, 3'd6, 5'd23, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    // Plain minute and hour carries.
    push_command(make_load(16'h5A5A, 4'd7, 5'd15, 3'd7, 5'd10, 6'd59, 6'd59));
    push_command(make_cmd(cct_pkg::CMD_TICK));
    wait_idle();
  endtask

  // Mostly rollover bursts, with fully random items as noise.
  task automatic test_random_traffic(input int idle, input int stall, input int n_items);
    int sent;
    int burst;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        send_rollover_burst(burst);
        sent += burst;
      end else begin
        push_command(random_payload());
        sent++;
      end
    end
    wait_idle();
  endtask

  // Hold the output for a long stretch while the sender keeps offering, so
  // the result register fills and the input stalls.
  task automatic test_output_holdoff();
    int burst;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 60;
    send_rollover_burst(burst);
    send_rollover_burst(burst);
    wait_idle();
  endtask

  // Short bursts, each followed by a full drain before the next.
  task automatic test_drain_pauses();
    int k;
    int j;
    idle_pct  = 8;
    stall_pct = 30;
    for (k = 0; k < 10; k++) begin
      for (j = 0; j < $urandom_range(1, 8); j++) begin
        push_command(random_payload());
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic(0, 0, 440);
    test_random_traffic(57, 0, 440);
    test_random_traffic(0, 57, 440);
    test_random_traffic(8, 8, 440);
    test_output_holdoff();
    test_drain_pauses();

    // Quiet tail: let any stray result show up before judging.
    stall_pct = 0;
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && cal_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cct_pkg.sv
rtl/calendar_clock_tick_unit.sv
test/tb_calendar_clock_tick_unit.sv
